// ===== design/gvs_pkg.sv =====
// Shared types, constants and control codes of the grid vorticity stencil.
package gvs_pkg;

  localparam int MAX_ROW_LEN_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_DATA_W      = 16;

  // Register indexes of the configuration port
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_COUNT  = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } sample_t;

  // Result jobs for one input, in delivery order
  typedef enum logic [1:0] {
    JOB_PREV_ROW    = 2'd0,  // same column of the previous row
    JOB_LAST_PREV   = 2'd1,  // previous column of the last row
    JOB_LAST_CORNER = 2'd2   // corner point of the last row
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_STARTX,
    S_DIVX,
    S_STARTY,
    S_DIVY,
    S_DIFF,
    S_LOAD,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_next;
    logic latch_old;
    logic latch_nxt;
    job_t job;
    logic div_start;
    logic div_sel_y;
    logic latch_qx;
    logic latch_qy;
    logic latch_diff;
    logic load_out;
    logic last;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic en_prev_row;
    logic en_last_prev;
    logic en_last_corner;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ===== design/gvs_if.sv =====
// Valid/ready channel interfaces for input samples and vorticity results.
interface gvs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic signed [31:0] u_vel;
  logic signed [31:0] v_vel;
  modport source (output valid, x_pos, y_pos, u_vel, v_vel, input ready);
  modport sink   (input valid, x_pos, y_pos, u_vel, v_vel, output ready);
endinterface

interface gvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vorticity;
  logic [9:0]         col_index;
  logic [15:0]        row_index;
  logic               zero_denominator;
  logic               saturated;
  logic               last_of_run;
  modport source (output valid, vorticity, col_index, row_index, zero_denominator,
                  saturated, last_of_run, input ready);
  modport sink   (input valid, vorticity, col_index, row_index, zero_denominator,
                  saturated, last_of_run, output ready);
endinterface

// ===== design/grid_vorticity_stencil_top.sv =====
// Top level of the grid vorticity stencil: controller plus datapath.
// Usage: flow samples (x_pos, y_pos, u_vel, v_vel, signed Q16.16) enter on the
// samples channel in raster order, row_length points per row, row_count rows.
// Vorticity results leave on the results channel, one row behind the input;
// on the last row each input also releases the previous column's result and,
// at the last column, the corner. last_of_run marks the final result of an input.
// Configuration: cfg_we with cfg_index 0 (row_length) or 1 (row_count) and
// cfg_data; a write restarts the frame at column 0, row 0. Write only when idle.
// Timing: one input item at a time. An item is accepted, takes two line buffer
// reads and a commit, and for each result runs the two quotients through one
// bit-serial divider.
// Reset: synchronous rst clears counters, previous samples and the output valid
// flag; row_length and row_count return to 2. The line buffer needs no clear.
// Stall: a result sits in the output register until taken; the next result of
// the same item is computed meanwhile and waits for that register to free up.
module grid_vorticity_stencil_top #(
  parameter int MAX_ROW_LEN = gvs_pkg::MAX_ROW_LEN_DEF,
  parameter int FRAC_BITS   = gvs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [gvs_pkg::CFG_DATA_W-1:0] cfg_data,
  gvs_in_if.sink                         samples,
  gvs_out_if.source                      results
);
  gvs_pkg::cmd_t    cmd;
  gvs_pkg::status_t status;

  gvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .status   (status),
    .cmd      (cmd)
  );

  gvs_dp #(.MAX_ROW_LEN(MAX_ROW_LEN), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .samples   (samples),
    .results   (results)
  );
endmodule

// ===== design/gvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gvs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/gvs_div.sv =====
// Restoring divider, one quotient bit per cycle: (|num| << FRAC_BITS) / |den|, signed result.
module gvs_div #(
  parameter int FRAC_BITS = gvs_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [32:0]           num,
  input  logic signed [32:0]           den,
  output logic                         done,
  output logic                         zero,
  output logic signed [FRAC_BITS+33:0] quot
);
  localparam int N  = 33 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  dvd;
  logic [32:0]   md;
  logic [33:0]   rem;
  logic [N-1:0]  q;
  logic          neg;
  logic [32:0]   mn_c;
  logic [33:0]   rem_sh;

  assign mn_c   = num[32] ? 33'(-num) : 33'(num);
  assign rem_sh = {rem[32:0], dvd[N-1]};

  // Control: busy count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(N);
        end
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= N'(mn_c) << FRAC_BITS;
      md   <= den[32] ? 33'(-den) : 33'(den);
      rem  <= '0;
      q    <= '0;
      neg  <= num[32] ^ den[32];
      zero <= (den == '0);
    end else if (busy) begin
      dvd <= dvd << 1;
      if (rem_sh >= {1'b0, md}) begin
        rem <= rem_sh - {1'b0, md};
        q   <= {q[N-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[N-2:0], 1'b0};
      end
    end
  end

  assign quot = zero ? '0 : (neg ? -$signed({1'b0, q}) : $signed({1'b0, q}));
endmodule

// ===== design/gvs_dp.sv =====
// Datapath: config, counters, line buffer, operand select, divider, result register.
module gvs_dp #(
  parameter int MAX_ROW_LEN = gvs_pkg::MAX_ROW_LEN_DEF,
  parameter int FRAC_BITS   = gvs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gvs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  gvs_pkg::cmd_t                 cmd,
  output gvs_pkg::status_t              status,
  gvs_in_if.sink                        samples,
  gvs_out_if.source                     results
);
  localparam int COL_W = (MAX_ROW_LEN > 2) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_ROW_LEN + 1);
  localparam int LW    = (LEN_W > 11) ? LEN_W : 11;
  localparam int QW    = FRAC_BITS + 34;
  localparam int DW    = QW + 1;
  localparam logic signed [DW-1:0] W_MAX = {{(DW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [DW-1:0] W_MIN = {{(DW-31){1'b1}}, {31{1'b0}}};

  logic [10:0]       row_length;
  logic [15:0]       row_count;
  logic [LW-1:0]     len_eff;
  logic [15:0]       rows_eff;
  logic [COL_W-1:0]  col;
  logic [15:0]       row;
  logic              col_last;
  logic              row_last;

  gvs_pkg::sample_t cur, old, nxt, disp, prev, rdata;
  gvs_pkg::sample_t op_a, op_b, op_c, op_d;

  logic signed [32:0]   div_num, div_den;
  logic                 div_done, div_zero;
  logic signed [QW-1:0] div_q;
  logic signed [QW-1:0] qx, qy;
  logic                 zx;
  logic                 zflag;
  logic signed [DW-1:0] diff;
  logic [COL_W-1:0]     res_col;
  logic [15:0]          res_row;

  // Effective geometry, clamped
  always_comb begin
    if (LW'(row_length) < LW'(2)) begin
      len_eff = LW'(2);
    end else if (LW'(row_length) > LW'(MAX_ROW_LEN)) begin
      len_eff = LW'(MAX_ROW_LEN);
    end else begin
      len_eff = LW'(row_length);
    end
    rows_eff = (row_count < 16'd2) ? 16'd2 : row_count;
  end

  assign col_last = (LW'(col) + LW'(1) == len_eff);
  assign row_last = (row == rows_eff - 16'd1);

  assign status.en_prev_row    = (row != 16'd0);
  assign status.en_last_prev   = row_last && (col != '0);
  assign status.en_last_corner = row_last && col_last;
  assign status.div_done       = div_done;
  assign status.out_busy       = results.valid;

  // Configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 11'd2;
      row_count  <= 16'd2;
      col        <= '0;
      row        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gvs_pkg::REG_ROW_LENGTH: row_length <= cfg_data[10:0];
        gvs_pkg::REG_ROW_COUNT:  row_count  <= cfg_data;
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (cmd.commit) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Line buffer holding the previous row
  gvs_ram #(.WIDTH($bits(gvs_pkg::sample_t)), .DEPTH(MAX_ROW_LEN)) u_line (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (col),
    .wdata (cur),
    .raddr (cmd.rd_next ? col + COL_W'(1) : col),
    .rdata (rdata)
  );

  assign samples.ready = cmd.capture;

  // Sample registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp <= '0;
      prev <= '0;
    end else if (cmd.commit) begin
      disp <= old;
      prev <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && samples.valid) begin
      cur <= '{x: samples.x_pos, y: samples.y_pos, u: samples.u_vel, v: samples.v_vel};
    end
    if (cmd.latch_old) begin
      old <= rdata;
    end
    if (cmd.latch_nxt) begin
      nxt <= rdata;
    end
  end

  // Operand select per job: a->b along the row, c->d across rows
  always_comb begin
    op_a    = prev;
    op_b    = cur;
    op_c    = old;
    op_d    = cur;
    res_col = col;
    res_row = row;
    unique case (cmd.job)
      gvs_pkg::JOB_PREV_ROW: begin
        op_a    = col_last ? disp : old;
        op_b    = col_last ? old : nxt;
        op_c    = old;
        op_d    = cur;
        res_row = row - 16'd1;
      end
      gvs_pkg::JOB_LAST_PREV: begin
        op_c    = disp;
        op_d    = prev;
        res_col = col - COL_W'(1);
      end
      gvs_pkg::JOB_LAST_CORNER: ;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.div_sel_y) begin
      div_num = 33'(op_d.u) - 33'(op_c.u);
      div_den = 33'(op_d.y) - 33'(op_c.y);
    end else begin
      div_num = 33'(op_b.v) - 33'(op_a.v);
      div_den = 33'(op_b.x) - 33'(op_a.x);
    end
  end

  gvs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .zero  (div_zero),
    .quot  (div_q)
  );

  // Quotients and their difference
  always_ff @(posedge clk) begin
    if (cmd.latch_qx) begin
      qx <= div_q;
      zx <= div_zero;
    end
    if (cmd.latch_qy) begin
      qy    <= div_q;
      zflag <= zx | div_zero;
    end
    if (cmd.latch_diff) begin
      diff <= DW'(qx) - DW'(qy);
    end
  end

  // Output register, saturated to 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (diff > W_MAX) begin
        results.vorticity <= 32'sh7fffffff;
        results.saturated <= 1'b1;
      end else if (diff < W_MIN) begin
        results.vorticity <= 32'sh80000000;
        results.saturated <= 1'b1;
      end else begin
        results.vorticity <= 32'(diff);
        results.saturated <= 1'b0;
      end
      results.col_index        <= 10'(res_col);
      results.row_index        <= res_row;
      results.zero_denominator <= zflag;
      results.last_of_run      <= cmd.last;
    end
  end
endmodule

// ===== design/gvs_ctrl.sv =====
// Controller: sequences line buffer reads, result jobs, divisions and commit.
module gvs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  gvs_pkg::status_t status,
  output gvs_pkg::cmd_t    cmd
);
  gvs_pkg::state_t state, state_next;
  gvs_pkg::job_t   job, job_next;
  gvs_pkg::job_t   first_job, after_job;
  logic            any_job, has_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gvs_pkg::S_IDLE;
      job   <= gvs_pkg::JOB_PREV_ROW;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  // First enabled job, and the job after the current one
  always_comb begin
    any_job   = status.en_prev_row | status.en_last_prev | status.en_last_corner;
    first_job = status.en_prev_row  ? gvs_pkg::JOB_PREV_ROW :
                status.en_last_prev ? gvs_pkg::JOB_LAST_PREV : gvs_pkg::JOB_LAST_CORNER;
    has_after = 1'b0;
    after_job = gvs_pkg::JOB_LAST_CORNER;
    unique case (job)
      gvs_pkg::JOB_PREV_ROW: begin
        has_after = status.en_last_prev | status.en_last_corner;
        after_job = status.en_last_prev ? gvs_pkg::JOB_LAST_PREV : gvs_pkg::JOB_LAST_CORNER;
      end
      gvs_pkg::JOB_LAST_PREV: begin
        has_after = status.en_last_corner;
      end
      gvs_pkg::JOB_LAST_CORNER: ;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    job_next   = job;
    unique case (state)
      gvs_pkg::S_IDLE:   if (in_valid) state_next = gvs_pkg::S_RD1;
      gvs_pkg::S_RD1:    state_next = gvs_pkg::S_RD2;
      gvs_pkg::S_RD2: begin
        job_next   = first_job;
        state_next = any_job ? gvs_pkg::S_STARTX : gvs_pkg::S_COMMIT;
      end
      gvs_pkg::S_STARTX: state_next = gvs_pkg::S_DIVX;
      gvs_pkg::S_DIVX:   if (status.div_done) state_next = gvs_pkg::S_STARTY;
      gvs_pkg::S_STARTY: state_next = gvs_pkg::S_DIVY;
      gvs_pkg::S_DIVY:   if (status.div_done) state_next = gvs_pkg::S_DIFF;
      gvs_pkg::S_DIFF:   state_next = gvs_pkg::S_LOAD;
      gvs_pkg::S_LOAD: begin
        if (!status.out_busy) begin
          if (has_after) begin
            job_next   = after_job;
            state_next = gvs_pkg::S_STARTX;
          end else begin
            state_next = gvs_pkg::S_COMMIT;
          end
        end
      end
      gvs_pkg::S_COMMIT: state_next = gvs_pkg::S_IDLE;
      default:           state_next = gvs_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.job  = job;
    cmd.last = !has_after;
    unique case (state)
      gvs_pkg::S_IDLE:   cmd.capture = 1'b1;
      gvs_pkg::S_RD1: begin
        cmd.latch_old = 1'b1;
        cmd.rd_next   = 1'b1;
      end
      gvs_pkg::S_RD2:    cmd.latch_nxt = 1'b1;
      gvs_pkg::S_STARTX: cmd.div_start = 1'b1;
      gvs_pkg::S_DIVX:   cmd.latch_qx = status.div_done;
      gvs_pkg::S_STARTY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      gvs_pkg::S_DIVY:   cmd.latch_qy = status.div_done;
      gvs_pkg::S_DIFF:   cmd.latch_diff = 1'b1;
      gvs_pkg::S_LOAD:   cmd.load_out = !status.out_busy;
      gvs_pkg::S_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== bench/tb_grid_vorticity_stencil_top.sv =====
// Self-checking testbench for the grid vorticity stencil top level.
module tb_grid_vorticity_stencil_top;

  localparam int LIMIT    = 1000000;
  localparam int SETTLE   = 400;
  localparam int ROW_MAX  = 1024;
  localparam int FRAC     = 16;

  typedef struct {
    logic signed [31:0] w;
    logic [9:0]         col;
    logic [15:0]        row;
    bit                 zd;
    bit                 sat;
    bit                 last;
  } vort_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = gvs_pkg::REG_ROW_LENGTH;
  logic [gvs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gvs_in_if  smp();
  gvs_out_if res();

  grid_vorticity_stencil_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(smp), .results(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stencil state mirrored for prediction
  gvs_pkg::sample_t line_buf [ROW_MAX];
  gvs_pkg::sample_t line_disp;
  gvs_pkg::sample_t last_in;
  int         col_cnt, row_cnt;
  int         len_reg, rows_reg;

  gvs_pkg::sample_t sample_q[$];
  vort_t      vort_q[$];
  int         err_cnt, sent_cnt, got_cnt, cyc;
  bit         in_acc, out_acc, send_hold, calm;
  int         gap, stall, hold_cnt;
  gvs_pkg::sample_t cur_item;

  initial begin
    for (int i = 0; i < ROW_MAX; i++) line_buf[i] = '0;
    line_disp = '0; last_in = '0;
    col_cnt = 0; row_cnt = 0; len_reg = 2; rows_reg = 2;
    err_cnt = 0; sent_cnt = 0; got_cnt = 0; cyc = 0;
    in_acc = 0; out_acc = 0; send_hold = 0; calm = 0;
    gap = 0; stall = 0; hold_cnt = 0;
    smp.valid = 1'b0; smp.x_pos = '0; smp.y_pos = '0; smp.u_vel = '0; smp.v_vel = '0;
    res.ready = 1'b0;
  end

  // Signed fixed-point quotient, truncated toward zero
  function automatic longint fx_quot(input longint num, input longint den, inout bit z);
    longint mn, md, q;
    if (den == 0) begin
      z = 1;
      return 0;
    end
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn <<< FRAC) / md;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // a->b along the row, c->d across rows
  function automatic vort_t curl_point(gvs_pkg::sample_t a, gvs_pkg::sample_t b,
                                       gvs_pkg::sample_t c, gvs_pkg::sample_t d,
                                       int col, int row);
    vort_t  o;
    bit     z;
    longint dvdx, dudy, w;
    z = 0;
    dvdx = fx_quot(longint'(b.v) - longint'(a.v), longint'(b.x) - longint'(a.x), z);
    dudy = fx_quot(longint'(d.u) - longint'(c.u), longint'(d.y) - longint'(c.y), z);
    w = dvdx - dudy;
    o.sat = 0;
    if (w > 64'sd2147483647) begin
      w = 64'sd2147483647; o.sat = 1;
    end else if (w < -64'sd2147483648) begin
      w = -64'sd2147483648; o.sat = 1;
    end
    o.w = w[31:0];
    o.col = col[9:0];
    o.row = row[15:0];
    o.zd = z;
    o.last = 0;
    return o;
  endfunction

  function automatic int eff_len(int raw);
    return raw < 2 ? 2 : (raw > ROW_MAX ? ROW_MAX : raw);
  endfunction

  function automatic int eff_rows(int raw);
    return raw < 2 ? 2 : raw;
  endfunction

  // Work out the results one accepted sample releases
  task automatic predict_vort(gvs_pkg::sample_t cur);
    vort_t   o[3];
    gvs_pkg::sample_t old;
    int      n, c, r, len, rows;
    n = 0;
    len = eff_len(len_reg);
    rows = eff_rows(rows_reg);
    c = col_cnt < len ? col_cnt : len - 1;
    r = row_cnt < rows ? row_cnt : rows - 1;
    old = line_buf[c];
    if (r >= 1) begin
      if (c + 1 < len) o[n++] = curl_point(old, line_buf[c+1], old, cur, c, r - 1);
      else o[n++] = curl_point(line_disp, old, old, cur, c, r - 1);
    end
    if (r == rows - 1) begin
      if (c >= 1) o[n++] = curl_point(last_in, cur, line_disp, last_in, c - 1, r);
      if (c == len - 1) o[n++] = curl_point(last_in, cur, old, cur, c, r);
    end
    if (n > 0) o[n-1].last = 1;
    for (int i = 0; i < n; i++) vort_q.push_back(o[i]);
    line_disp = old;
    line_buf[c] = cur;
    last_in = cur;
    if (c + 1 >= len) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, got_cnt);
    err_cnt++;
  endtask

  // Input side: accept detection
  always @(posedge clk) begin
    if (!rst && smp.valid && smp.ready) begin
      predict_vort(cur_item);
      sent_cnt++;
      in_acc = 1;
    end
  end

  // Input side: driver
  always @(negedge clk) begin
    if (!rst) begin
      if (smp.valid && in_acc) begin
        smp.valid <= 1'b0;
        in_acc = 0;
        gap = calm ? 0 : $urandom_range(0, 8);
      end else if (!smp.valid) begin
        if (gap > 0) gap--;
        else if (sample_q.size() > 0 && !send_hold) begin
          cur_item = sample_q.pop_front();
          smp.x_pos <= cur_item.x;
          smp.y_pos <= cur_item.y;
          smp.u_vel <= cur_item.u;
          smp.v_vel <= cur_item.v;
          smp.valid <= 1'b1;
        end
      end
    end
  end

  // Output side: check each transaction against the oldest prediction
  always @(posedge clk) begin
    vort_t e;
    if (!rst && res.valid && res.ready) begin
      if (vort_q.size() == 0) begin
        report("unexpected result, vorticity", res.vorticity, 0);
      end else begin
        e = vort_q.pop_front();
        if (res.vorticity !== e.w) report("vorticity", res.vorticity, e.w);
        if (res.col_index !== e.col) report("col_index", res.col_index, e.col);
        if (res.row_index !== e.row) report("row_index", res.row_index, e.row);
        if (res.zero_denominator !== e.zd) report("zero_denominator", res.zero_denominator, e.zd);
        if (res.saturated !== e.sat) report("saturated", res.saturated, e.sat);
        if (res.last_of_run !== e.last) report("last_of_run", res.last_of_run, e.last);
      end
      got_cnt++;
      out_acc = 1;
    end
  end

  // Long receiver hold-off, counted down on its own
  always @(negedge clk) begin
    if (hold_cnt > 0) hold_cnt--;
  end

  // Output side: ready with random stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (res.ready && (out_acc || hold_cnt > 0)) begin
        res.ready <= 1'b0;
        out_acc = 0;
        stall = calm ? 0 : $urandom_range(0, 8);
      end else if (!res.ready && hold_cnt == 0) begin
        if (stall > 0) stall--;
        else res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("tb_grid_vorticity_stencil_top: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (sample_q.size() == 0 && !smp.valid && vort_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers written back to back; each write restarts the frame
  task automatic set_grid(int len_raw, int rows_raw);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= gvs_pkg::REG_ROW_LENGTH;
    cfg_data <= len_raw[gvs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= gvs_pkg::REG_ROW_COUNT; cfg_data <= rows_raw[gvs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    len_reg = len_raw & 'h7FF;
    rows_reg = rows_raw & 'hFFFF;
    col_cnt = 0;
    row_cnt = 0;
  endtask

  function automatic logic [31:0] corner_val(int k);
    case (k % 4)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] vel_val();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return $urandom;
    return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
  endfunction

  // Raster samples on a regular grid, with some noise and broken points
  task automatic push_grid(int n, int len_raw, int rows_raw);
    gvs_pkg::sample_t s;
    int      c, r, len, rows, k;
    logic signed [31:0] x0, y0, dx, dy;
    len = eff_len(len_raw & 'h7FF);
    rows = eff_rows(rows_raw & 'hFFFF);
    c = 0; r = 0;
    x0 = $urandom; y0 = $urandom;
    dx = $urandom_range(1, 32'h4_0000); dy = $urandom_range(1, 32'h4_0000);
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    if ($urandom_range(0, 19) == 0) dx = 0;
    if ($urandom_range(0, 19) == 0) dy = 0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      s.x = x0 + c * dx;
      s.y = y0 + r * dy;
      s.u = vel_val();
      s.v = vel_val();
      if (k == 0) begin
        s.x = $urandom; s.y = $urandom;
      end else if (k == 1) begin
        s.x = x0 + (c - 1) * dx;
      end else if (k == 2) begin
        s.y = y0 + (r - 1) * dy;
      end
      sample_q.push_back(s);
      if (c + 1 >= len) begin
        c = 0;
        r = (r + 1 >= rows) ? 0 : r + 1;
      end else c++;
    end
  endtask

  initial begin
    gvs_pkg::sample_t s;
    int      rnd_items, len_raw, rows_raw, n, phases;
    phases = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes on the smallest grid
    set_grid(2, 2);
    for (int i = 0; i < 16; i++) begin
      s.x = corner_val(i);
      s.y = corner_val(i / 4);
      s.u = corner_val(i + 1);
      s.v = corner_val(i + 2);
      sample_q.push_back(s);
    end
    wait_drained();

    // Directed: 3x3 frame, then clamped register values
    set_grid(3, 3);
    push_grid(9, 3, 3);
    wait_drained();
    set_grid(0, 0);
    push_grid(8, 0, 0);
    wait_drained();
    set_grid(1, 1);
    push_grid(6, 1, 1);
    wait_drained();
    // Widest rows: only the first row arrives, so no results come back
    set_grid(2047, 65535);
    push_grid(10, 2047, 65535);
    wait_drained();
    set_grid(1024, 2);
    push_grid(4, 1024, 2);
    wait_drained();
    phases = 6;

    // Random frames, mostly small grids
    rnd_items = 0;
    while (rnd_items < 200) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) len_raw = $urandom_range(7, 40);
      else len_raw = $urandom_range(2, 6);
      rows_raw = $urandom_range(2, 5);
      n = $urandom_range(10, 40);
      set_grid(len_raw, rows_raw);
      if (phases == 8) begin
        // Receiver holds off while the sender keeps offering
        hold_cnt = 3000;
        push_grid(n, len_raw, rows_raw);
      end else if (phases == 10) begin
        // Sender pauses mid-frame until every result is back
        push_grid(n / 2, len_raw, rows_raw);
        wait (sample_q.size() == 0 && !smp.valid);
        send_hold = 1;
        wait (vort_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        send_hold = 0;
        push_grid(n - n / 2, len_raw, rows_raw);
      end else begin
        push_grid(n, len_raw, rows_raw);
      end
      rnd_items += n;
      wait_drained();
      phases++;
    end
    calm = 0;

    $display("covered %0d samples, %0d results over %0d grid settings", sent_cnt, got_cnt,
             phases);
    $display("grids from 2x2 to wide rows, clamped registers, field extremes, long stalls");
    if (err_cnt == 0 && vort_q.size() == 0) begin
      $display("tb_grid_vorticity_stencil_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", err_cnt, vort_q.size());
      $display("tb_grid_vorticity_stencil_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gvs_pkg.sv
design/gvs_if.sv
design/gvs_ram.sv
design/gvs_div.sv
design/gvs_dp.sv
design/gvs_ctrl.sv
design/grid_vorticity_stencil_top.sv
bench/tb_grid_vorticity_stencil_top.sv
